// File: rtl/dft_bin_magnitude_db_assert.svh
// Assertion macros shared by the RTL files.
// Each check is sampled on clk and held off while rst_n is low.
`ifndef DFT_BIN_MAGNITUDE_DB_ASSERT_SVH
`define DFT_BIN_MAGNITUDE_DB_ASSERT_SVH
`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define DBMD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");
// The consequent must hold in the cycle after the antecedent.
`define DBMD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");
`else
`define DBMD_ASSERT_NOW(label, ante, cons)
`define DBMD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: rtl/dbmd_pkg.sv
package dbmd_pkg;

  // Store depth (a power of two) and stored sample width (at most 16)
  localparam int POINTS      = 1024;
  localparam int SAMPLE_BITS = 16;

  localparam int IW  = $clog2(POINTS);        // sample / twiddle index width
  localparam int AW  = SAMPLE_BITS + IW + 18; // accumulator and vectoring width
  localparam int MW  = AW - 2;                // magnitude width
  localparam int EW  = $clog2(MW);            // exponent width
  localparam int GLW = 25;                    // low part of the vectoring result
  localparam int TWW = 16;                    // twiddle width, Q14 in [-1, 1]

  localparam int VEC_STEPS = 32;
  localparam int SQ_STEPS  = 16;
  localparam int ROT_STEPS = 30;

  localparam logic signed [31:0] GAIN_Q30          = 32'sd652032874;
  localparam logic signed [31:0] DB_PER_OCTAVE_Q24 = 32'sd50504453;

  // Input kind
  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_QUERY = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    T_IDLE,
    T_ACC,
    T_POST,
    T_WAIT
  } top_state_t;

  typedef enum logic [1:0] {
    A_IDLE,
    A_RUN,
    A_DRAIN
  } acc_state_t;

  typedef enum logic [3:0] {
    P_IDLE,
    P_VEC,
    P_GAIN_HI,
    P_GAIN_LO,
    P_SUM,
    P_NORM,
    P_SQ_MUL,
    P_SQ_ADJ,
    P_DB_MUL,
    P_DB_FIN,
    P_DONE
  } post_state_t;

  // Sample store write port
  typedef struct packed {
    logic                   en;
    logic [IW-1:0]          addr;
    logic [SAMPLE_BITS-1:0] data;
  } wr_req_t;

  // Query start toward the accumulator
  typedef struct packed {
    logic          start;
    logic [IW-1:0] kb;
  } acc_ctl_t;

  // Twiddle table: entry m holds {sin, cos}, Q14 each
  typedef logic [POINTS-1:0][2*TWW-1:0] tw_tab_t;

  localparam longint TURN_ATAN [ROT_STEPS] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
    64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
    64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001
  };

  // Round a Q30 value to Q14 and clamp to [-1, 1]
  function automatic longint q30_to_q14(longint v);
    longint r;
    r = (v + 64'sd32768) >>> 16;
    if (r > 64'sd16384) r = 64'sd16384;
    if (r < -64'sd16384) r = -64'sd16384;
    return r;
  endfunction

  // Rotation CORDIC per entry, evaluated at elaboration
  function automatic tw_tab_t build_tw();
    tw_tab_t t;
    longint  p, z, cx, cy, dx, dy, cq, sq, c, s;
    int      quad;
    for (int m = 0; m < POINTS; m++) begin
      p    = (longint'(m) <<< 32) / POINTS;
      quad = int'((p >>> 30) & 64'sd3);
      z    = p & 64'sh3FFFFFFF;
      cx   = 64'sd652032874;
      cy   = 64'sd0;
      for (int i = 0; i < ROT_STEPS; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (z >= 0) begin
          cx = cx - dx; cy = cy + dy; z = z - TURN_ATAN[i];
        end else begin
          cx = cx + dx; cy = cy - dy; z = z + TURN_ATAN[i];
        end
      end
      cq = q30_to_q14(cx);
      sq = q30_to_q14(cy);
      case (quad)
        0:       begin c = cq;  s = sq;  end
        1:       begin c = -sq; s = cq;  end
        2:       begin c = -cq; s = -sq; end
        default: begin c = sq;  s = -cq; end
      endcase
      t[m] = {s[TWW-1:0], c[TWW-1:0]};
    end
    return t;
  endfunction

endpackage

// File: rtl/dbmd_accum.sv
// Sample store, twiddle ROM and the multiply-accumulate pair.
// One sample per cycle; done rises when the last product has been accumulated.
module dbmd_accum (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dbmd_pkg::wr_req_t             wr,
  input  dbmd_pkg::acc_ctl_t            ctl,
  output logic                          done,
  output logic signed [dbmd_pkg::AW-1:0] acc_re,
  output logic signed [dbmd_pkg::AW-1:0] acc_im
);
  import dbmd_pkg::*;

  `include "dft_bin_magnitude_db_assert.svh"

  localparam tw_tab_t TW_ROM = build_tw();
  localparam int      PRW    = SAMPLE_BITS + TWW;

  logic [SAMPLE_BITS-1:0] sample_mem [POINTS];

  acc_state_t              state_r, state_nxt;
  logic [IW-1:0]           j_r, idx_r, kb_r;
  logic                    v1_r, v2_r, issue;
  logic [SAMPLE_BITS-1:0]  smp_q_r;
  logic [2*TWW-1:0]        tw_q_r;
  logic signed [PRW-1:0]   prod_re_r, prod_im_r;
  logic signed [AW-1:0]    acc_re_r, acc_im_r;

  // Store write and registered reads
  always_ff @(posedge clk) begin
    if (wr.en) begin
      sample_mem[wr.addr] <= wr.data;
    end
    smp_q_r <= sample_mem[j_r];
    tw_q_r  <= TW_ROM[idx_r];
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      A_IDLE:  if (ctl.start) state_nxt = A_RUN;
      A_RUN:   if (j_r == IW'(POINTS - 1)) state_nxt = A_DRAIN;
      A_DRAIN: if (!v1_r && !v2_r) state_nxt = A_IDLE;
      default: state_nxt = A_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    issue = (state_r == A_RUN);
    done  = (state_r == A_DRAIN) && !v1_r && !v2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= issue;
      v2_r    <= v1_r;
    end
  end

  // Address walk: j over samples, idx = k*j mod POINTS
  always_ff @(posedge clk) begin
    if (ctl.start && state_r == A_IDLE) begin
      j_r   <= '0;
      idx_r <= '0;
      kb_r  <= ctl.kb;
    end else if (issue) begin
      j_r   <= j_r + 1'b1;
      idx_r <= idx_r + kb_r;
    end
  end

  // Products, then accumulate
  always_ff @(posedge clk) begin
    if (v1_r) begin
      prod_re_r <= $signed(smp_q_r) * $signed(tw_q_r[TWW-1:0]);
      prod_im_r <= $signed(smp_q_r) * $signed(tw_q_r[2*TWW-1:TWW]);
    end
    if (ctl.start && state_r == A_IDLE) begin
      acc_re_r <= '0;
      acc_im_r <= '0;
    end else if (v2_r) begin
      acc_re_r <= acc_re_r + AW'(prod_re_r);
      acc_im_r <= acc_im_r - AW'(prod_im_r);
    end
  end

  assign acc_re = acc_re_r;
  assign acc_im = acc_im_r;

  `DBMD_ASSERT_NOW(a_issue_run, issue, state_r == A_RUN)
  `DBMD_ASSERT_NEXT(a_drain_entry, state_r == A_RUN && j_r == IW'(POINTS - 1), v1_r)
  `DBMD_ASSERT_NOW(a_done_empty, done, !v1_r && !v2_r)

endmodule

// File: rtl/dbmd_post.sv
// Magnitude, amplitude and level from the two sums.
// One shared 32x32 signed multiplier serves the gain, the squarings and
// the dB scale; the vectoring and normalizing steps run one per cycle.
module dbmd_post (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic signed [dbmd_pkg::AW-1:0] re,
  input  logic signed [dbmd_pkg::AW-1:0] im,
  output logic                           done,
  output logic [15:0]                    amplitude,
  output logic [15:0]                    level_db
);
  import dbmd_pkg::*;

  `include "dft_bin_magnitude_db_assert.svh"

  localparam int AMPW = MW - IW - 12;
  localparam int CW   = $clog2(VEC_STEPS);
  localparam int LGW  = EW + 16;
  localparam int DW   = LGW + 2;
  localparam logic signed [DW-1:0] LG_OFS = DW'(28 * 65536);

  post_state_t            state_r, state_nxt;
  logic signed [AW-1:0]   gx_r, gy_r;
  logic [CW-1:0]          cnt_r;
  logic signed [31:0]     mul_a, mul_b;
  logic signed [63:0]     mul_q_r;
  logic [MW-1:0]          mag_r, mag_nxt, nm_r;
  logic [EW-1:0]          e_r;
  logic [30:0]            m_r;
  logic [15:0]            frac_r;
  logic [31:0]            sq;
  logic [LGW-1:0]         lg;
  logic signed [DW-1:0]   d;
  logic [MW:0]            amp_sum;
  logic [AMPW-1:0]        amp_full;
  logic signed [63:0]     db_sum;
  logic signed [31:0]     db_r;
  logic [15:0]            amp_r, level_r;
  logic                   zero_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      P_IDLE:    if (start) state_nxt = P_VEC;
      P_VEC:     if (cnt_r == CW'(VEC_STEPS - 1)) state_nxt = P_GAIN_HI;
      P_GAIN_HI: state_nxt = P_GAIN_LO;
      P_GAIN_LO: state_nxt = P_SUM;
      P_SUM:     state_nxt = (mag_nxt == '0) ? P_DONE : P_NORM;
      P_NORM:    if (nm_r[MW-1]) state_nxt = P_SQ_MUL;
      P_SQ_MUL:  state_nxt = P_SQ_ADJ;
      P_SQ_ADJ:  state_nxt = (cnt_r == CW'(SQ_STEPS - 1)) ? P_DB_MUL : P_SQ_MUL;
      P_DB_MUL:  state_nxt = P_DB_FIN;
      P_DB_FIN:  state_nxt = P_DONE;
      P_DONE:    state_nxt = P_IDLE;
      default:   state_nxt = P_IDLE;
    endcase
  end

  // Shared multiplier operand select
  always_comb begin
    lg = {e_r, frac_r};
    d  = $signed({2'b00, lg}) - LG_OFS;
    unique case (state_r)
      P_GAIN_HI: begin
        mul_a = 32'(gx_r[AW-1:GLW]);
        mul_b = GAIN_Q30;
      end
      P_GAIN_LO: begin
        mul_a = 32'(gx_r[GLW-1:0]);
        mul_b = GAIN_Q30;
      end
      P_SQ_MUL: begin
        mul_a = 32'(m_r);
        mul_b = 32'(m_r);
      end
      P_DB_MUL: begin
        mul_a = 32'(d);
        mul_b = DB_PER_OCTAVE_Q24;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Derived values used by the sequencer
  always_comb begin
    mag_nxt  = mag_r + MW'(mul_q_r[GLW+29:30]);
    amp_sum  = {1'b0, mag_nxt} + (MW+1)'(2 ** (IW + 12));
    amp_full = amp_sum[MW:IW+13];
    sq       = mul_q_r[61:30];
    db_sum   = mul_q_r + 64'sd2147483648;
    db_r     = db_sum[63:32];
    done     = (state_r == P_DONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= P_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    mul_q_r <= mul_a * mul_b;
    unique case (state_r)
      P_IDLE: begin
        if (start) begin
          gx_r  <= (re < 0) ? -re : re;
          gy_r  <= (im < 0) ? -im : im;
          cnt_r <= '0;
        end
      end
      P_VEC: begin
        if (gy_r >= 0) begin
          gx_r <= gx_r + (gy_r >>> cnt_r);
          gy_r <= gy_r - (gx_r >>> cnt_r);
        end else begin
          gx_r <= gx_r - (gy_r >>> cnt_r);
          gy_r <= gy_r + (gx_r >>> cnt_r);
        end
        cnt_r <= cnt_r + 1'b1;
      end
      P_GAIN_LO: begin
        mag_r <= mul_q_r[MW+4:5];
      end
      P_SUM: begin
        nm_r   <= mag_nxt;
        e_r    <= EW'(MW - 1);
        zero_r <= (mag_nxt == '0);
        amp_r  <= (amp_full > AMPW'(16'hFFFF)) ? 16'hFFFF : amp_full[15:0];
      end
      P_NORM: begin
        if (nm_r[MW-1]) begin
          m_r    <= nm_r[MW-1 -: 31];
          frac_r <= '0;
          cnt_r  <= '0;
        end else begin
          nm_r <= {nm_r[MW-2:0], 1'b0};
          e_r  <= e_r - 1'b1;
        end
      end
      P_SQ_ADJ: begin
        m_r    <= sq[31] ? sq[31:1] : sq[30:0];
        frac_r <= {frac_r[14:0], sq[31]};
        cnt_r  <= cnt_r + 1'b1;
      end
      P_DB_FIN: begin
        if (db_r > 32'sd32767) begin
          level_r <= 16'h7FFF;
        end else if (db_r < -32'sd32768) begin
          level_r <= 16'h8000;
        end else begin
          level_r <= db_r[15:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign amplitude = amp_r;
  assign level_db  = zero_r ? 16'h8000 : level_r;

  `DBMD_ASSERT_NEXT(a_vec_done, state_r == P_VEC && cnt_r == CW'(VEC_STEPS - 1),
                    state_r == P_GAIN_HI)
  `DBMD_ASSERT_NOW(a_norm_lead, state_r == P_SQ_MUL, m_r[30])
  `DBMD_ASSERT_NEXT(a_zero_skip, state_r == P_SUM && mag_nxt == '0, state_r == P_DONE)

endmodule

// File: rtl/dft_bin_magnitude_db.sv
// One bin of a direct DFT over a store of POINTS samples, reported as
// amplitude 2|X|/POINTS (unsigned Q2.14, saturated) and level 10*log10|X|
// (signed Q8.8; a zero magnitude gives -32768). A load item (tuser = 0)
// writes one sample; a load beyond the store is dropped. A query item
// (tuser = 1) names bin k (taken mod POINTS) and produces one result. A
// query runs the multiply-accumulate walk over the sample store, one
// sample per cycle through the store read port, then the post-processing
// sequencer (32 vectoring steps, a normalize of up to 41 shifts and 16
// squarings through its shared multiplier); a zero magnitude skips to the
// end after the vectoring and gain steps. The input is not ready while a
// query is in work; a finished result waits in the output register, and
// the input stalls further only while a second result waits behind one
// not yet taken. Samples that were never loaded read as undefined.
module dft_bin_magnitude_db (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // position[9:0], sample[25:10], zero[31:26]
  input  logic        in_tuser,   // func[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // bin[9:0], amplitude[25:10], level_db[41:26], zero
);
  import dbmd_pkg::*;

  `include "dft_bin_magnitude_db_assert.svh"

  localparam int XW = IW + 10;

  top_state_t          state_r, state_nxt;
  logic                in_acc, out_free, out_load;
  logic [9:0]          in_pos;
  logic [XW-1:0]       pos_ext;
  logic [9:0]          bin_r;
  wr_req_t             wr;
  acc_ctl_t            acc_ctl;
  logic                acc_done, post_done, post_start;
  logic signed [AW-1:0] acc_re, acc_im;
  logic [15:0]         amp, lvl;
  logic                out_tvalid_r;
  logic [47:0]         out_tdata_r;

  assign in_pos  = in_tdata[9:0];
  assign pos_ext = XW'(in_pos);
  assign in_acc  = in_tvalid && in_tready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      T_IDLE: if (in_acc && in_tuser == FUNC_QUERY) state_nxt = T_ACC;
      T_ACC:  if (acc_done) state_nxt = T_POST;
      T_POST: if (post_done) state_nxt = out_free ? T_IDLE : T_WAIT;
      T_WAIT: if (out_free) state_nxt = T_IDLE;
      default: state_nxt = T_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_tready       = (state_r == T_IDLE);
    out_free        = !out_tvalid_r || out_tready;
    out_load        = ((state_r == T_POST && post_done) || state_r == T_WAIT) && out_free;
    post_start      = (state_r == T_ACC) && acc_done;
    wr.en           = in_acc && (in_tuser == FUNC_LOAD) && (pos_ext < XW'(POINTS));
    wr.addr         = pos_ext[IW-1:0];
    wr.data         = in_tdata[SAMPLE_BITS+9:10];
    acc_ctl.start   = in_acc && (in_tuser == FUNC_QUERY);
    acc_ctl.kb      = pos_ext[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= T_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (acc_ctl.start) begin
      bin_r <= in_pos;
    end
    if (out_load) begin
      out_tdata_r <= {6'd0, lvl, amp, bin_r};
    end
  end

  dbmd_accum u_accum (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (wr),
    .ctl    (acc_ctl),
    .done   (acc_done),
    .acc_re (acc_re),
    .acc_im (acc_im)
  );

  dbmd_post u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (post_start),
    .re        (acc_re),
    .im        (acc_im),
    .done      (post_done),
    .amplitude (amp),
    .level_db  (lvl)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  `DBMD_ASSERT_NEXT(a_query_starts, in_acc && in_tuser == FUNC_QUERY, state_r == T_ACC)
  `DBMD_ASSERT_NOW(a_acc_done_state, acc_done, state_r == T_ACC)
  `DBMD_ASSERT_NOW(a_post_done_state, post_done, state_r == T_POST)
  `DBMD_ASSERT_NOW(a_out_rise, $rose(out_tvalid_r),
                   $past(state_r) == T_POST || $past(state_r) == T_WAIT)

endmodule
